// ===== hw/rtl/cfps_pkg.sv =====
// Shared types and constants for the chain fork point search unit.
package cfps_pkg;

    localparam int HEIGHT_W = 64;
    localparam int CNT_W    = 16;

    // Configuration register indexes
    localparam logic REG_FINALIZED   = 1'b0;
    localparam logic REG_BATCH_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        CODE_CONTINUE   = 4'd0,
        CODE_BEHIND     = 4'd1,
        CODE_EQUAL      = 4'd2,
        CODE_LOWER      = 4'd3,
        CODE_TOO_MANY   = 4'd4,
        CODE_FORKED     = 4'd5,
        CODE_LIED       = 4'd6,
        CODE_UPDATED    = 4'd7,
        CODE_NOT_SYNCED = 4'd8,
        CODE_SEQUENCE   = 4'd9
    } code_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_FIRST = 3'b010,
        PH_LATER = 3'b100
    } phase_t;

    typedef enum logic {
        FUNC_STATS = 1'b0,
        FUNC_HASH  = 1'b1
    } func_t;

    // Classification of a hash-batch transaction, decided without search state
    typedef struct packed {
        logic too_many;
        logic fdi_zero;
        logic fdi_eq_rc;
        logic lc_is_two;
    } hash_cls_t;

    typedef struct packed {
        func_t                func;
        code_t                stat_code;
        logic [HEIGHT_W-1:0]  local_height;
        logic [HEIGHT_W-1:0]  remote_height;
        hash_cls_t            cls;
        logic [CNT_W-1:0]     fdi;
        logic [CNT_W-1:0]     lc;
        logic [CNT_W-1:0]     lc_minus_fdi;
    } entry_t;

endpackage

// ===== hw/rtl/cfps_front.sv =====
// Front end: accepts transactions and classifies them ahead of the queue.
module cfps_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [63:0]                  local_height,
    input  logic [63:0]                  remote_height,
    input  logic [63:0]                  local_score_hi,
    input  logic [63:0]                  local_score_lo,
    input  logic [63:0]                  remote_score_hi,
    input  logic [63:0]                  remote_score_lo,
    input  logic [15:0]                  first_diff_index,
    input  logic [15:0]                  local_hash_count,
    input  logic [15:0]                  remote_hash_count,
    input  logic [63:0]                  finalized_height,
    input  logic [15:0]                  hashes_per_batch,
    input  logic                         q_full,
    output logic                         q_push,
    output cfps_pkg::entry_t             q_data
);
    import cfps_pkg::*;

    localparam int CW = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
    localparam logic [CNT_W-1:0] CNT_MASK = CNT_W'((33'd1 << CW) - 33'd1);

    logic [CNT_W-1:0] fdi_m;
    logic [CNT_W-1:0] lc;
    logic [CNT_W-1:0] rc;
    logic [CNT_W-1:0] hpb;
    logic [CNT_W-1:0] fdi_a;
    logic [CNT_W-1:0] fdi_c;
    logic             remote_greater;
    logic             scores_equal;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        fdi_m = first_diff_index & CNT_MASK;
        lc    = local_hash_count & CNT_MASK;
        rc    = remote_hash_count & CNT_MASK;
        hpb   = hashes_per_batch & CNT_MASK;
        // clamp to the shorter of the two batches
        fdi_a = (fdi_m > lc) ? lc : fdi_m;
        fdi_c = (fdi_a > rc) ? rc : fdi_a;

        remote_greater = {remote_score_hi, remote_score_lo} > {local_score_hi, local_score_lo};
        scores_equal   = {remote_score_hi, remote_score_lo} == {local_score_hi, local_score_lo};

        q_data               = '0;
        q_data.func          = func_t'(func);
        q_data.local_height  = local_height;
        q_data.remote_height = remote_height;
        if (remote_height <= finalized_height)
        begin
            q_data.stat_code = CODE_BEHIND;
        end
        else if (remote_greater)
        begin
            q_data.stat_code = CODE_CONTINUE;
        end
        else if (scores_equal)
        begin
            q_data.stat_code = CODE_EQUAL;
        end
        else
        begin
            q_data.stat_code = CODE_LOWER;
        end
        q_data.cls.too_many  = (rc > hpb) || (rc == '0);
        q_data.cls.fdi_zero  = (fdi_c == '0);
        q_data.cls.fdi_eq_rc = (fdi_c == rc);
        q_data.cls.lc_is_two = (lc == CNT_W'(2));
        q_data.fdi           = fdi_c;
        q_data.lc            = lc;
        q_data.lc_minus_fdi  = lc - fdi_c;
    end

endmodule

// ===== hw/rtl/cfps_queue.sv =====
// Two-entry queue between the front end and the search sequencer.
module cfps_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cfps_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output cfps_pkg::entry_t  pop_data,
    output logic              not_empty
);
    import cfps_pkg::*;

    entry_t      mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/cfps_back.sv =====
// Search sequencer: holds the bisection window and produces one result per entry.
module cfps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  cfps_pkg::entry_t  q_data,
    output logic              q_pop,
    input  logic [63:0]       finalized_height,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [3:0]        code,
    output logic [63:0]       next_start_height,
    output logic [63:0]       common_height,
    output logic [63:0]       fork_depth,
    output logic              done_res
);
    import cfps_pkg::*;

    phase_t              phase_reg,  phase_next;
    logic [63:0]         lower_reg,  lower_next;
    logic [63:0]         upper_reg,  upper_next;
    logic [63:0]         start_reg,  start_next;
    logic [63:0]         sl_reg,     sl_next;
    logic [63:0]         sr_reg,     sr_next;
    logic [63:0]         common_reg, common_next;

    logic                out_valid_reg, out_valid_next;
    code_t               code_reg,   code_next;
    logic [63:0]         nsh_reg,    nsh_next;
    logic [63:0]         ch_reg,     ch_next;
    logic [63:0]         fd_reg,     fd_next;

    logic                take;
    logic [63:0]         derived;
    logic [63:0]         common;
    logic [64:0]         sum_lo;
    logic [64:0]         sum_hi;
    logic [63:0]         mid_lo;
    logic [63:0]         mid_hi;

    assign take  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = take;

    always_comb
    begin
        derived = start_reg + {48'd0, q_data.lc} - 64'd1;
        common  = start_reg + {48'd0, q_data.fdi} - 64'd1;
        sum_lo  = {1'b0, lower_reg} + {1'b0, start_reg};
        sum_hi  = {1'b0, start_reg} + {1'b0, upper_reg};
        mid_lo  = sum_lo[64:1];
        mid_hi  = sum_hi[64:1];

        phase_next  = phase_reg;
        lower_next  = lower_reg;
        upper_next  = upper_reg;
        start_next  = start_reg;
        sl_next     = sl_reg;
        sr_next     = sr_reg;
        common_next = common_reg;

        code_next = CODE_SEQUENCE;
        nsh_next  = 64'd0;
        ch_next   = '1;
        fd_next   = 64'd0;

        if (q_data.func == FUNC_STATS)
        begin
            lower_next = finalized_height;
            start_next = finalized_height;
            code_next  = q_data.stat_code;
            if (q_data.stat_code == CODE_CONTINUE)
            begin
                sl_next    = q_data.local_height;
                sr_next    = q_data.remote_height;
                upper_next = q_data.local_height;
                phase_next = PH_FIRST;
                nsh_next   = finalized_height;
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            code_next = CODE_SEQUENCE;
        end
        else if (q_data.cls.too_many)
        begin
            code_next = CODE_TOO_MANY;
        end
        else if (phase_reg == PH_FIRST && q_data.cls.fdi_zero)
        begin
            code_next = CODE_FORKED;
        end
        else if (q_data.cls.fdi_zero)
        begin
            // fork lies below this batch: pull the upper bound down
            upper_next = start_reg;
            if (mid_lo == start_reg)
            begin
                code_next = CODE_LIED;
            end
            else
            begin
                code_next  = CODE_CONTINUE;
                nsh_next   = mid_lo;
                start_next = mid_lo;
            end
        end
        else if (q_data.cls.fdi_eq_rc)
        begin
            if (derived >= sl_reg)
            begin
                if (derived < sr_reg)
                begin
                    // next start is derived - 1, which repeats the start only for two hashes
                    if (q_data.cls.lc_is_two)
                    begin
                        code_next = CODE_LIED;
                    end
                    else
                    begin
                        code_next  = CODE_CONTINUE;
                        nsh_next   = derived - 64'd1;
                        start_next = derived - 64'd1;
                    end
                end
                else
                begin
                    code_next = (derived == sl_reg) ? CODE_LIED : CODE_UPDATED;
                end
            end
            else
            begin
                lower_next = start_reg;
                if (mid_hi == start_reg)
                begin
                    code_next = CODE_LIED;
                end
                else
                begin
                    code_next  = CODE_CONTINUE;
                    nsh_next   = mid_hi;
                    start_next = mid_hi;
                end
            end
        end
        else
        begin
            code_next   = CODE_NOT_SYNCED;
            common_next = common;
            ch_next     = common;
            if (derived > sl_reg)
            begin
                sl_next = derived;
                fd_next = {48'd0, q_data.lc_minus_fdi};
            end
            else
            begin
                fd_next = sl_reg - common;
            end
        end

        if (q_data.func == FUNC_HASH && code_next == CODE_CONTINUE)
        begin
            phase_next = PH_LATER;
        end
        else if (code_next != CODE_CONTINUE)
        begin
            phase_next = PH_IDLE;
        end

        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            lower_reg     <= 64'd0;
            upper_reg     <= 64'd0;
            start_reg     <= 64'd0;
            sl_reg        <= 64'd0;
            sr_reg        <= 64'd0;
            common_reg    <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg  <= phase_next;
                lower_reg  <= lower_next;
                upper_reg  <= upper_next;
                start_reg  <= start_next;
                sl_reg     <= sl_next;
                sr_reg     <= sr_next;
                common_reg <= common_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            code_reg <= code_next;
            nsh_reg  <= nsh_next;
            ch_reg   <= ch_next;
            fd_reg   <= fd_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign code              = code_reg;
    assign next_start_height = nsh_reg;
    assign common_height     = ch_reg;
    assign fork_depth        = fd_reg;
    assign done_res          = (code_reg != CODE_CONTINUE);

`ifndef ASSERT_OFF
    a_sync_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && code != CODE_NOT_SYNCED) |-> (common_height == '1 && fork_depth == 64'd0))
        else $error("common height or fork depth set without not-synced code");
    a_continue_keeps_search: assert property (@(posedge clk) disable iff (!rst_n)
        (take && code_next == CODE_CONTINUE) |=> (phase_reg != PH_IDLE))
        else $error("search dropped after continue result");
    a_final_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        (take && code_next != CODE_CONTINUE) |=> (phase_reg == PH_IDLE))
        else $error("search still open after final result");
`endif

endmodule

// ===== hw/rtl/chain_fork_point_search_unit.sv =====
// Top level of the chain fork point search unit: configuration and block wiring.
// Bound registers close a loop; a result is registered from the queue head.
// Throughput: one transaction per cycle while out_ready is high.
// A two-entry queue lets the front end keep accepting while a result waits.
// Reset: search state clears and phase returns to idle; finalized_height resets to 0,
// hashes_per_batch to 64.
module chain_fork_point_search_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [63:0] local_height,
    input  logic [63:0] remote_height,
    input  logic [63:0] local_score_hi,
    input  logic [63:0] local_score_lo,
    input  logic [63:0] remote_score_hi,
    input  logic [63:0] remote_score_lo,
    input  logic [15:0] first_diff_index,
    input  logic [15:0] local_hash_count,
    input  logic [15:0] remote_hash_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  code,
    output logic [63:0] next_start_height,
    output logic [63:0] common_height,
    output logic [63:0] fork_depth,
    output logic        done_res
);
    import cfps_pkg::*;

    logic [63:0] finalized_reg;
    logic [15:0] hpb_reg;

    logic        q_full;
    logic        q_push;
    entry_t      q_wdata;
    logic        q_pop;
    entry_t      q_rdata;
    logic        q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finalized_reg <= 64'd0;
            hpb_reg       <= 16'd64;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_FINALIZED:   finalized_reg <= cfg_wdata;
                REG_BATCH_LIMIT: hpb_reg       <= cfg_wdata[15:0];
                default:         hpb_reg       <= hpb_reg;
            endcase
        end
    end

    cfps_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .local_height      (local_height),
        .remote_height     (remote_height),
        .local_score_hi    (local_score_hi),
        .local_score_lo    (local_score_lo),
        .remote_score_hi   (remote_score_hi),
        .remote_score_lo   (remote_score_lo),
        .first_diff_index  (first_diff_index),
        .local_hash_count  (local_hash_count),
        .remote_hash_count (remote_hash_count),
        .finalized_height  (finalized_reg),
        .hashes_per_batch  (hpb_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_data            (q_wdata)
    );

    cfps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_not_empty)
    );

    cfps_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_not_empty),
        .q_data            (q_rdata),
        .q_pop             (q_pop),
        .finalized_height  (finalized_reg),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .code              (code),
        .next_start_height (next_start_height),
        .common_height     (common_height),
        .fork_depth        (fork_depth),
        .done_res          (done_res)
    );

endmodule
